// ===== design/crc64rw_pkg.sv =====
// ----------------------------------------------------------------------------
// crc64rw_pkg
// Shared types, constants and elaboration-time matrix helpers for the
// reflected CRC-64 word engine.
// ----------------------------------------------------------------------------
package crc64rw_pkg;

	localparam int CRC_W      = 64;
	localparam int WORD_BYTES = 8;
	localparam int COUNT_W    = 4;

	typedef logic [CRC_W-1:0]   crc_t;
	typedef logic [COUNT_W-1:0] count_t;

	// reflected form of the polynomial
	localparam crc_t CRC_POLY = 64'h95AC9329AC4BC9B5;

	// row of the matrix for nbytes byte shifts: bit j tells whether input
	// bit j reaches output bit bit_idx after 8*nbytes reflected shift steps
	function automatic crc_t crc_row(input int nbytes, input int bit_idx);
		crc_t row;
		crc_t col;
		int   j;
		int   s;
		row = '0;
		for (j = 0; j < CRC_W; j++) begin
			col = crc_t'(1) << j;
			for (s = 0; s < 8 * nbytes; s++) begin
				col = col[0] ? ((col >> 1) ^ CRC_POLY) : (col >> 1);
			end
			row[j] = col[bit_idx];
		end
		return row;
	endfunction

endpackage

// ===== design/crc64rw_fold.sv =====
// ----------------------------------------------------------------------------
// crc64rw_fold
// Folds the valid low bytes of one word into a CRC register in one pass:
// the masked word is xored onto the register, then the register is pushed
// through the constant shift matrix chosen by the byte count.
// ----------------------------------------------------------------------------
module crc64rw_fold (
	input  crc64rw_pkg::crc_t   crc_in,
	input  crc64rw_pkg::crc_t   data_word,
	input  crc64rw_pkg::count_t byte_count,
	output crc64rw_pkg::crc_t   crc_out
);

	localparam int NCAND = crc64rw_pkg::WORD_BYTES + 1;

	crc64rw_pkg::count_t count_sat;
	crc64rw_pkg::crc_t   byte_mask;
	crc64rw_pkg::crc_t   x;
	crc64rw_pkg::crc_t   cand [0:NCAND-1];

	// counts above a full word saturate
	always_comb begin
		if (byte_count > crc64rw_pkg::count_t'(crc64rw_pkg::WORD_BYTES)) begin
			count_sat = crc64rw_pkg::count_t'(crc64rw_pkg::WORD_BYTES);
		end else begin
			count_sat = byte_count;
		end
	end

	// keep only the valid low bytes
	always_comb begin
		for (int i = 0; i < crc64rw_pkg::WORD_BYTES; i++) begin
			byte_mask[8*i +: 8] = (crc64rw_pkg::count_t'(i) < count_sat) ? 8'hff : 8'h00;
		end
	end

	assign x = crc_in ^ (data_word & byte_mask);

	// one candidate per byte count, each a constant xor matrix
	for (genvar k = 0; k < NCAND; k++) begin : g_cand
		for (genvar b = 0; b < crc64rw_pkg::CRC_W; b++) begin : g_bit
			localparam crc64rw_pkg::crc_t ROW = crc64rw_pkg::crc_row(k, b);
			assign cand[k][b] = ^(x & ROW);
		end
	end

	assign crc_out = cand[count_sat];

endmodule

// ===== design/crc64_reflected_word_engine.sv =====
// ----------------------------------------------------------------------------
// crc64_reflected_word_engine
// Reflected CRC-64 over a stream of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one message word and its count of valid low bytes,
//   s_tuser marks the first word of a message. The first word of a message
//   starts from the inverted initial_crc written on the configuration port;
//   later words continue from the running register. Each word yields one
//   word on m_tdata: the inverted running CRC after its bytes.
//   A word is taken when s_tvalid and s_tready are both high, a result is
//   taken when m_tvalid and m_tready are both high.
// Timing:
//   a word taken into the input register is folded and handed to the running
//   and result registers, which raise m_tvalid; one word per cycle is sustained
//   while m_tready holds high. The whole fold of a word is one xor-matrix pass
//   between the input register and the running/result registers.
// Reset and stall:
//   reset empties both stages, sets the running register to all ones and
//   initial_crc to zero. While the receiver stalls, the result stays in the
//   output register and one more word can still be taken into the input
//   register; after that s_tready drops until the result is taken.
// Configuration is to be written only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module crc64_reflected_word_engine (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [63:0] cfg_wr_data,   // initial_crc
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,       // data_word [63:0], byte_count [67:64], zero pad
	input  logic        s_tuser,       // first
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata        // crc_value
);

	crc64rw_pkg::crc_t   init_q;
	crc64rw_pkg::crc_t   run_q;

	logic                valid_s1;
	crc64rw_pkg::crc_t   data_s1;
	crc64rw_pkg::count_t count_s1;
	logic                first_s1;

	logic                advance;
	crc64rw_pkg::crc_t   start_crc;
	crc64rw_pkg::crc_t   next_crc;

	// handoff from the input register to the result register
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
		end else if (cfg_wr_en) begin
			init_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1  <= s_tdata[63:0];
			count_s1 <= s_tdata[67:64];
			first_s1 <= s_tuser;
		end
	end

	// starting register for this word
	assign start_crc = first_s1 ? ~init_q : run_q;

	crc64rw_fold u_fold (
		.crc_in     (start_crc),
		.data_word  (data_s1),
		.byte_count (count_s1),
		.crc_out    (next_crc)
	);

	// running register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '1;
		end else if (advance) begin
			run_q <= next_crc;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= ~next_crc;
		end
	end

	// result shown always matches the running register it came from
	a_result_matches_run : assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_tvalid && (m_tdata == ~run_q)))
		else $error("result does not match running register");

	// running register only moves on a handoff
	a_run_holds : assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(run_q))
		else $error("running register changed without a handoff");

	// an empty output register never blocks the input side
	a_ready_when_empty : assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// a stalled result keeps the input register from draining
	a_stall_blocks : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && valid_s1) |-> !s_tready)
		else $error("input accepted while both stages are full and stalled");

endmodule
